// ----- sv/amrp_pkg.sv -----
// ----------------------------------------------------------------------------
// amrp_pkg
// Shared constants and types of the manufacturer record parser.
// ----------------------------------------------------------------------------
package amrp_pkg;

	// record layout
	localparam logic [7:0] MFR_TYPE     = 8'hFF;
	localparam logic [7:0] MIN_MFR_LEN  = 8'd13;
	localparam logic [7:0] NICK_OFFSET  = 8'd14;
	localparam logic [7:0] TYPE_OFFSET  = 8'd4;
	localparam logic [7:0] NONCE_OFFSET = 8'd5;
	localparam int         NONCE_BYTES  = 8;

	// configuration registers
	localparam int         CFG_IDX_W  = 1;
	localparam int         CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPANY_ID = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NICK_LIMIT = 1'd1;
	localparam logic [15:0] COMPANY_ID_RST     = 16'd0;
	localparam logic [7:0]  NICK_LIMIT_RST     = 8'd16;

	// results caused by one input byte: an optional nickname byte, then an
	// optional blob summary
	typedef struct packed {
		logic        has_nick;
		logic        has_sum;
		logic [7:0]  nick_byte;
		logic [7:0]  nick_index;
		logic        found;
		logic [7:0]  record_type;
		logic [63:0] nonce;
		logic [7:0]  nick_count;
	} res_pair_t;

endpackage

// ----- sv/amrp_if.sv -----
// ----------------------------------------------------------------------------
// amrp_in_if / amrp_out_if
// Valid/ready channels of the manufacturer record parser.
// ----------------------------------------------------------------------------
interface amrp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ad_byte;
	logic [7:0] blob_len;

	modport source(output valid, ad_byte, blob_len, input ready);
	modport sink(input valid, ad_byte, blob_len, output ready);
endinterface

interface amrp_out_if;
	logic        valid;
	logic        ready;
	logic        out_kind;
	logic [7:0]  nick_byte;
	logic [7:0]  nick_index;
	logic        found;
	logic [7:0]  record_type;
	logic [63:0] nonce;
	logic [7:0]  nick_count;
	logic        result_last;

	modport source(output valid, out_kind, nick_byte, nick_index, found, record_type,
		nonce, nick_count, result_last, input ready);
	modport sink(input valid, out_kind, nick_byte, nick_index, found, record_type,
		nonce, nick_count, result_last, output ready);
endinterface

// ----- sv/adv_manufacturer_record_parser_unit.sv -----
// ----------------------------------------------------------------------------
// adv_manufacturer_record_parser_unit
// Length-type-value walk over advertising data, manufacturer record match.
// ----------------------------------------------------------------------------
// The parser takes one advertising byte per cycle while ready is high: each
// request is parsed in the cycle it is accepted and its results land in an
// output register, with a one-entry skid behind it, so input and output stall
// independently. A byte gives at most two results (a nickname byte and, on the
// blob's last byte, the summary); the output register presents one result at a
// time, so when the blob's last byte also carries a nickname byte the summary
// waits behind it, and ready drops only while the skid entry is occupied.
module adv_manufacturer_record_parser_unit
	import amrp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	amrp_in_if.sink               ad,
	amrp_out_if.source            res
);

	typedef enum logic [2:0] {
		PH_LEN, PH_TYPE, PH_SKIP, PH_CO_LO, PH_CO_HI, PH_HEADER, PH_NICK, PH_DONE
	} phase_t;

	logic [15:0] company_id_q;
	logic [7:0]  nick_limit_q;

	phase_t      phase_q, phase_n;
	logic [7:0]  byte_pos_q;
	logic [7:0]  rec_start_q, rec_start_n;
	logic [7:0]  rec_len_q, rec_len_n;
	logic [7:0]  type_q, type_n;
	logic [63:0] nonce_q, nonce_n;
	logic [7:0]  nick_rem_q, nick_rem_n;
	logic [7:0]  nick_done_q, nick_done_n;
	logic        found_q, found_n;

	res_pair_t   main_q, skid_q, new_res;
	logic        main_valid_q, skid_valid_q;

	logic        in_acc, last, rec_end, len_over, produce, main_pop, out_acc;
	logic [7:0]  b, off, nick_len;
	logic [2:0]  lane;
	phase_t      after_rec;

	assign b       = ad.ad_byte;
	assign in_acc  = ad.valid && ad.ready;
	assign ad.ready = !skid_valid_q;
	assign last    = ({1'b0, byte_pos_q} + 9'd1) >= {1'b0, ad.blob_len};
	assign off     = byte_pos_q - rec_start_q;
	assign rec_end = {1'b0, byte_pos_q} >= ({1'b0, rec_start_q} + {1'b0, rec_len_q});
	assign after_rec = rec_end ? PH_LEN : PH_SKIP;
	assign len_over = ({2'b0, byte_pos_q} + 10'd1 + {2'b0, b}) > {2'b0, ad.blob_len};
	assign nick_len = (b > nick_limit_q) ? nick_limit_q : b;
	assign lane     = 3'(off - NONCE_OFFSET);

	always_comb begin
		phase_n     = phase_q;
		rec_start_n = rec_start_q;
		rec_len_n   = rec_len_q;
		type_n      = type_q;
		nonce_n     = nonce_q;
		nick_rem_n  = nick_rem_q;
		nick_done_n = nick_done_q;
		found_n     = found_q;
		new_res     = '0;
		case (phase_q)
			PH_LEN: begin
				if (b == 8'd0 || len_over) begin
					phase_n = PH_DONE;
				end else begin
					rec_start_n = byte_pos_q;
					rec_len_n   = b;
					phase_n     = PH_TYPE;
				end
			end
			PH_TYPE: begin
				if (b == MFR_TYPE && rec_len_q >= MIN_MFR_LEN) begin
					phase_n = PH_CO_LO;
				end else begin
					phase_n = after_rec;
				end
			end
			PH_SKIP: begin
				phase_n = after_rec;
			end
			PH_CO_LO: begin
				phase_n = (b == company_id_q[7:0]) ? PH_CO_HI : after_rec;
			end
			PH_CO_HI: begin
				if (b == company_id_q[15:8]) begin
					found_n = 1'b1;
					phase_n = PH_HEADER;
				end else begin
					phase_n = after_rec;
				end
			end
			PH_HEADER: begin
				if (off == TYPE_OFFSET) begin
					type_n = b;
				end else if (off >= NONCE_OFFSET && off < NICK_OFFSET - 8'd1) begin
					for (int k = 0; k < NONCE_BYTES; k++) begin
						if (lane == 3'(k)) begin
							nonce_n[8*k +: 8] = nonce_q[8*k +: 8] | b;
						end
					end
				end else begin
					nick_rem_n = nick_len;
					phase_n    = (nick_len == 8'd0) ? PH_DONE : PH_NICK;
				end
			end
			PH_NICK: begin
				new_res.has_nick   = 1'b1;
				new_res.nick_byte  = b;
				new_res.nick_index = nick_done_q;
				nick_done_n        = nick_done_q + 8'd1;
				nick_rem_n         = nick_rem_q - 8'd1;
				if (nick_rem_q == 8'd1) begin
					phase_n = PH_DONE;
				end
			end
			default: begin
			end
		endcase
		// summary reports the state as left by this byte
		new_res.has_sum     = last;
		new_res.found       = last && found_n;
		new_res.record_type = last ? type_n : 8'd0;
		new_res.nonce       = last ? nonce_n : 64'd0;
		new_res.nick_count  = last ? nick_done_n : 8'd0;
	end

	assign produce  = new_res.has_nick || new_res.has_sum;
	assign out_acc  = res.valid && res.ready;
	assign main_pop = out_acc && !(main_q.has_nick && main_q.has_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			company_id_q <= COMPANY_ID_RST;
			nick_limit_q <= NICK_LIMIT_RST;
			phase_q      <= PH_LEN;
			byte_pos_q   <= '0;
			rec_start_q  <= '0;
			rec_len_q    <= '0;
			type_q       <= '0;
			nonce_q      <= '0;
			nick_rem_q   <= '0;
			nick_done_q  <= '0;
			found_q      <= 1'b0;
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
			main_q       <= '0;
			skid_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_COMPANY_ID: company_id_q <= cfg_data[15:0];
					CFG_NICK_LIMIT: nick_limit_q <= cfg_data[7:0];
					default: begin
					end
				endcase
			end

			if (in_acc) begin
				if (last) begin
					phase_q     <= PH_LEN;
					byte_pos_q  <= '0;
					rec_start_q <= '0;
					rec_len_q   <= '0;
					type_q      <= '0;
					nonce_q     <= '0;
					nick_rem_q  <= '0;
					nick_done_q <= '0;
					found_q     <= 1'b0;
				end else begin
					phase_q     <= phase_n;
					byte_pos_q  <= byte_pos_q + 8'd1;
					rec_start_q <= rec_start_n;
					rec_len_q   <= rec_len_n;
					type_q      <= type_n;
					nonce_q     <= nonce_n;
					nick_rem_q  <= nick_rem_n;
					nick_done_q <= nick_done_n;
					found_q     <= found_n;
				end
			end

			// output register with one skid entry behind it
			if (out_acc && !main_pop) begin
				main_q.has_nick <= 1'b0;
				// summary still waits, a new request goes behind it
				if (in_acc && produce) begin
					skid_q       <= new_res;
					skid_valid_q <= 1'b1;
				end
			end else if (skid_valid_q) begin
				if (main_pop) begin
					main_q       <= skid_q;
					skid_valid_q <= 1'b0;
				end
			end else if (in_acc && produce) begin
				if (!main_valid_q || main_pop) begin
					main_q       <= new_res;
					main_valid_q <= 1'b1;
				end else begin
					skid_q       <= new_res;
					skid_valid_q <= 1'b1;
				end
			end else if (main_pop) begin
				main_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		res.valid       = main_valid_q;
		res.out_kind    = !main_q.has_nick;
		res.nick_byte   = 8'd0;
		res.nick_index  = 8'd0;
		res.found       = 1'b0;
		res.record_type = 8'd0;
		res.nonce       = 64'd0;
		res.nick_count  = 8'd0;
		res.result_last = 1'b1;
		if (main_q.has_nick) begin
			res.nick_byte   = main_q.nick_byte;
			res.nick_index  = main_q.nick_index;
			res.result_last = !main_q.has_sum;
		end else begin
			res.found       = main_q.found;
			res.record_type = main_q.record_type;
			res.nonce       = main_q.nonce;
			res.nick_count  = main_q.nick_count;
		end
	end

`ifndef SYNTHESIS
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry held with empty output register");

	a_summary_after_nick: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && main_q.has_nick && main_q.has_sum)
		|=> (main_valid_q && !main_q.has_nick && main_q.has_sum))
		else $error("summary lost after nickname byte");

	a_nick_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_NICK) |-> (found_q && nick_rem_q != 8'd0))
		else $error("nickname phase without a matched record");

	a_pos_in_blob: assert property (@(posedge clk) disable iff (!arst_n)
		byte_pos_q != 8'hFF)
		else $error("byte position ran past any blob length");
`endif

endmodule
